// ===== hw/rtl/ncoi_pkg.sv =====
package ncoi_pkg;

   // field widths of the table access request and its data
   localparam int OCT_W   = 4;
   localparam int VOICE_W = 3;
   localparam int VALUE_W = 16;

   // command codes
   localparam logic CMD_COMPUTE = 1'b0;
   localparam logic CMD_WRITE   = 1'b1;

   // table contents after reset: base plus octave times step
   localparam int BASE_OFFSET  = 6500;
   localparam int OCTAVE_SCALE = 65535 / 13;

   // note / 12 as (note * 171) >> 11, exact for 7-bit notes
   localparam int RECIP12       = 171;
   localparam int RECIP12_SHIFT = 11;

   // x / 3 as (x * 5462) >> 14, exact for 12-bit x
   localparam int RECIP3        = 5462;
   localparam int RECIP3_SHIFT  = 14;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ_A,
      ST_READ_B,
      ST_EXTRAP,
      ST_CLAMP,
      ST_INTERP
   } state_type;

   // table access request from the sequencer
   typedef struct packed {
      logic               wr;
      logic               rd;
      logic [OCT_W-1:0]   oct;
      logic [VOICE_W-1:0] voice;
   } tbl_cmd_type;

endpackage

// ===== hw/rtl/note_to_cv_octave_interpolator.sv =====
// Note to control value converter with a per-voice octave table.
// Input: command word on the req_ ports, taken at a clock edge where start is
// high and busy is low. A write word loads one table entry; a compute word
// returns one control value on rsp_control_value, marked by rsp_strobe for
// exactly one cycle. The receiver cannot hold results off.
// Timing:
//   pitch compute: result strobed the cycle after accept, busy stays low,
//                  so one word per cycle
//   table compute: result strobed after states READ_A, READ_B, EXTRAP and INTERP
//                  (CLAMP too when the next octave lies above the table); busy meanwhile
//   table write:   busy in the WRITE state, no result
// Throughput of table computes is set by the single 32x16 multiplier, used
// once for extrapolation and once for interpolation, and the one table read
// port, read twice per word.
// Reset: sequencer goes idle, no strobe, all table entries return to
// 6500 + octave * 5041 at once.
module note_to_cv_octave_interpolator #(
   parameter int OCTAVE_SLOTS = 8,
   parameter int VOICE_SLOTS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [2:0]  req_voice,
   input  logic [6:0]  req_note,
   input  logic [7:0]  req_fraction,
   input  logic        req_is_pitch,
   input  logic [2:0]  req_octave_slot,
   input  logic [15:0] req_entry_value,
   output logic        rsp_strobe,
   output logic [15:0] rsp_control_value
);

   ncoi_pkg::state_type   state_ff, state_in;
   ncoi_pkg::tbl_cmd_type tbl_cmd;
   logic [15:0]           tbl_rd_data;
   logic [15:0]           tbl_wr_data;

   logic [2:0]  voice_ff, voice_in;
   logic [3:0]  q_ff, q_in;
   logic [3:0]  r_ff, r_in;
   logic [7:0]  frac_ff, frac_in;
   logic [2:0]  slot_ff, slot_in;
   logic [15:0] value_ff, value_in;
   logic [15:0] semi_ff, semi_in;
   logic [15:0] a_ff, a_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] d_ff, d_in;
   logic [15:0] lo_ff, lo_in;
   logic [15:0] hi_ff, hi_in;
   logic [15:0] res_ff, res_in;
   logic        strobe_ff, strobe_in;

   logic        accept;
   logic [2:0]  vmod;
   logic [14:0] q_prod;
   logic [6:0]  r_full;
   logic [4:0]  q_plus1;
   logic [4:0]  m_sum;
   logic        extrap;
   logic [3:0]  oct_a;
   logic [3:0]  oct_b;
   logic [11:0] x;
   logic [24:0] third_prod;
   logic [16:0] semi_sum;
   logic [31:0] mul_a;
   logic [15:0] mul_b;
   logic [47:0] mul_full;
   logic [31:0] mul_p;
   logic [31:0] lo_raw;
   logic [31:0] span;

   assign accept = start && (state_ff == ncoi_pkg::ST_IDLE);

   // voice folded onto the existing rows
   always_comb begin
      vmod = req_voice;
      for (int i = 0; i < (1 << ncoi_pkg::VOICE_W); i++) begin
         if (5'(vmod) >= 5'(VOICE_SLOTS)) begin
            vmod = vmod - 3'(VOICE_SLOTS);
         end
      end
   end

   // octave and semitone of the note
   assign q_prod = 15'(req_note) * 15'(ncoi_pkg::RECIP12);
   assign q_in   = q_prod[14:ncoi_pkg::RECIP12_SHIFT];
   assign r_full = req_note - 7'({q_in, 3'b000}) - 7'({q_in, 2'b00});
   assign r_in   = r_full[3:0];

   // octave position: (r*256 + frac) * 64 / 3 = 21x + x/3
   assign x          = {r_ff, frac_ff};
   assign third_prod = 25'(x) * 25'(ncoi_pkg::RECIP3);
   assign semi_sum   = 17'(x) * 17'd21 + 17'(third_prod[24:ncoi_pkg::RECIP3_SHIFT]);

   // octaves above the table use the top two entries
   assign q_plus1 = 5'(q_ff) + 5'd1;
   assign extrap  = (q_plus1 >= 5'(OCTAVE_SLOTS));
   assign m_sum   = 5'(q_ff) + 5'd2 - 5'(OCTAVE_SLOTS);
   assign oct_a   = extrap ? 4'(OCTAVE_SLOTS - 2) : q_ff;
   assign oct_b   = extrap ? 4'(OCTAVE_SLOTS - 1) : q_plus1[3:0];

   // shared multiplier, low 32 bits kept
   assign mul_full = {16'd0, mul_a} * {32'd0, mul_b};
   assign mul_p    = mul_full[31:0];

   assign lo_raw = acc_ff - d_ff;
   assign span   = {16'd0, hi_ff} - {16'd0, lo_ff};

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ncoi_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      voice_ff <= voice_in;
      frac_ff  <= frac_in;
      slot_ff  <= slot_in;
      value_ff <= value_in;
      semi_ff  <= semi_in;
      a_ff     <= a_in;
      acc_ff   <= acc_in;
      d_ff     <= d_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      res_ff   <= res_in;
      if (accept) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      strobe_in   = 1'b0;
      voice_in    = voice_ff;
      frac_in     = frac_ff;
      slot_in     = slot_ff;
      value_in    = value_ff;
      semi_in     = semi_ff;
      a_in        = a_ff;
      acc_in      = acc_ff;
      d_in        = d_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      res_in      = res_ff;
      tbl_cmd     = '0;
      tbl_wr_data = value_ff;
      mul_a       = span;
      mul_b       = semi_ff;
      case (state_ff)
         ncoi_pkg::ST_IDLE: begin
            if (accept) begin
               voice_in = vmod;
               frac_in  = req_fraction;
               slot_in  = req_octave_slot;
               value_in = req_entry_value;
               if (req_command == ncoi_pkg::CMD_WRITE) begin
                  state_in = ncoi_pkg::ST_WRITE;
               end else if (req_is_pitch) begin
                  res_in    = {1'b0, req_note, req_fraction};
                  strobe_in = 1'b1;
               end else begin
                  state_in = ncoi_pkg::ST_READ_A;
               end
            end
         end
         ncoi_pkg::ST_WRITE: begin
            tbl_cmd.wr    = (5'(slot_ff) < 5'(OCTAVE_SLOTS));
            tbl_cmd.oct   = 4'(slot_ff);
            tbl_cmd.voice = voice_ff;
            state_in      = ncoi_pkg::ST_IDLE;
         end
         ncoi_pkg::ST_READ_A: begin
            tbl_cmd.rd    = 1'b1;
            tbl_cmd.oct   = oct_a;
            tbl_cmd.voice = voice_ff;
            semi_in       = semi_sum[15:0];
            state_in      = ncoi_pkg::ST_READ_B;
         end
         ncoi_pkg::ST_READ_B: begin
            tbl_cmd.rd    = 1'b1;
            tbl_cmd.oct   = oct_b;
            tbl_cmd.voice = voice_ff;
            a_in          = tbl_rd_data;
            state_in      = ncoi_pkg::ST_EXTRAP;
         end
         ncoi_pkg::ST_EXTRAP: begin
            // upper entry: top + (top - sub) * steps above the table
            d_in   = {16'd0, tbl_rd_data} - {16'd0, a_ff};
            mul_a  = d_in;
            mul_b  = 16'(m_sum[3:0]);
            acc_in = mul_p + {16'd0, tbl_rd_data};
            if (extrap) begin
               state_in = ncoi_pkg::ST_CLAMP;
            end else begin
               lo_in    = a_ff;
               hi_in    = tbl_rd_data;
               state_in = ncoi_pkg::ST_INTERP;
            end
         end
         ncoi_pkg::ST_CLAMP: begin
            // lower entry is one step below the upper one
            lo_in    = (|lo_raw[31:16]) ? 16'hFFFF : lo_raw[15:0];
            hi_in    = (|acc_ff[31:16]) ? 16'hFFFF : acc_ff[15:0];
            state_in = ncoi_pkg::ST_INTERP;
         end
         ncoi_pkg::ST_INTERP: begin
            mul_a     = span;
            mul_b     = semi_ff;
            res_in    = lo_ff + mul_p[31:16];
            strobe_in = 1'b1;
            state_in  = ncoi_pkg::ST_IDLE;
         end
         default: begin
            state_in = ncoi_pkg::ST_IDLE;
         end
      endcase
   end

   ncoi_table #(
      .OCTAVE_SLOTS (OCTAVE_SLOTS),
      .VOICE_SLOTS  (VOICE_SLOTS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tbl_cmd),
      .wr_data (tbl_wr_data),
      .rd_data (tbl_rd_data)
   );

   assign busy              = (state_ff != ncoi_pkg::ST_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_control_value = res_ff;

endmodule

// ===== hw/rtl/ncoi_table.sv =====
module ncoi_table #(
   parameter int OCTAVE_SLOTS = 8,
   parameter int VOICE_SLOTS  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ncoi_pkg::tbl_cmd_type                cmd,
   input  logic [ncoi_pkg::VALUE_W-1:0]         wr_data,
   output logic [ncoi_pkg::VALUE_W-1:0]         rd_data
);

   localparam int DEPTH  = OCTAVE_SLOTS * VOICE_SLOTS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SUM_W  = 9;

   logic [ncoi_pkg::VALUE_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]             valid_ff;
   logic [ncoi_pkg::VALUE_W-1:0] rd_data_ff;
   logic [ncoi_pkg::OCT_W-1:0]   rd_oct_ff;
   logic                         rd_valid_ff;
   logic [SUM_W-1:0]             addr_sum;
   logic [ADDR_W-1:0]            addr;
   logic [16:0]                  reset_sum;

   // row-major address: octave row, voice column
   assign addr_sum = SUM_W'(cmd.oct) * SUM_W'(VOICE_SLOTS) + SUM_W'(cmd.voice);
   assign addr     = addr_sum[ADDR_W-1:0];

   // single port memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem_ff[addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem_ff[addr];
         rd_oct_ff  <= cmd.oct;
      end
   end

   // written flags, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr) begin
            valid_ff[addr] <= 1'b1;
         end
         if (cmd.rd) begin
            rd_valid_ff <= valid_ff[addr];
         end
      end
   end

   // unwritten entries read as their power-on value
   assign reset_sum = 17'(ncoi_pkg::BASE_OFFSET)
                    + 17'(rd_oct_ff) * 17'(ncoi_pkg::OCTAVE_SCALE);
   assign rd_data   = rd_valid_ff ? rd_data_ff : reset_sum[15:0];

endmodule

// ===== hw/rtl/ncoi_checker.sv =====
module ncoi_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_command,
   input logic [2:0]  req_voice,
   input logic [6:0]  req_note,
   input logic [7:0]  req_fraction,
   input logic        req_is_pitch,
   input logic [2:0]  req_octave_slot,
   input logic [15:0] req_entry_value,
   input logic        rsp_strobe,
   input logic [15:0] rsp_control_value
);

   logic accept;

   assign accept = start && !busy;

   // reset leaves the block idle and silent
   assert property (@(posedge clock) reset |=> !busy && !rsp_strobe)
      else $error("not idle after reset");

   // pitch word answers next cycle with the direct mapping
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == ncoi_pkg::CMD_COMPUTE && req_is_pitch) |=>
      (rsp_strobe && rsp_control_value == {1'b0, $past(req_note), $past(req_fraction)}))
      else $error("pitch result wrong");

   // table compute holds off new words and shows no early result
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == ncoi_pkg::CMD_COMPUTE && !req_is_pitch) |=>
      (busy && !rsp_strobe))
      else $error("table compute not busy");

   // write goes busy, then idle again, and returns nothing
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == ncoi_pkg::CMD_WRITE) |=>
      (busy && !rsp_strobe) ##1 (!busy && !rsp_strobe))
      else $error("write sequence wrong");

endmodule

bind note_to_cv_octave_interpolator ncoi_checker u_ncoi_checker (.*);

// ===== sim/tb_note_to_cv_octave_interpolator.sv =====
module tb_note_to_cv_octave_interpolator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OCTAVE_SLOTS = 8;
   localparam int VOICE_SLOTS  = 8;
   localparam int OCT_IDX_W    = $clog2(OCTAVE_SLOTS);
   localparam int VOICE_IDX_W  = $clog2(VOICE_SLOTS);
   localparam int STALL_LIMIT  = 200;
   localparam int DRAIN_CYCLES = 10;

   // one control value waiting on the result port
   typedef struct {
      logic [15:0] cv;
      logic [6:0]  note;
      logic [7:0]  fraction;
      logic [2:0]  voice;
      logic        is_pitch;
   } cv_pending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = ncoi_pkg::CMD_COMPUTE;
   logic [2:0]  req_voice = '0;
   logic [6:0]  req_note = '0;
   logic [7:0]  req_fraction = '0;
   logic        req_is_pitch = 1'b0;
   logic [2:0]  req_octave_slot = '0;
   logic [15:0] req_entry_value = '0;
   logic        rsp_strobe;
   logic [15:0] rsp_control_value;

   // mirror of the per-voice octave rows
   logic [15:0]    tune_rows [VOICE_SLOTS][OCTAVE_SLOTS];
   cv_pending_type pending_cv [$];
   cv_pending_type head_cv;

   int idle_pct = 28;
   int mismatch_count = 0;
   int stall_cycles = 0;
   int n_writes = 0;
   int n_pitch = 0;
   int n_table = 0;
   int n_extrap = 0;
   int n_checked = 0;

   note_to_cv_octave_interpolator #(
      .OCTAVE_SLOTS(OCTAVE_SLOTS),
      .VOICE_SLOTS (VOICE_SLOTS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_voice        (req_voice),
      .req_note         (req_note),
      .req_fraction     (req_fraction),
      .req_is_pitch     (req_is_pitch),
      .req_octave_slot  (req_octave_slot),
      .req_entry_value  (req_entry_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_control_value(rsp_control_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // level of one octave, extrapolated and clamped above the row
   function automatic logic [31:0] octave_level(logic [VOICE_IDX_W-1:0] v, logic [31:0] oct);
      logic [31:0] top;
      logic [31:0] sub;
      logic [31:0] acc;
      if (oct < OCTAVE_SLOTS) begin
         return {16'd0, tune_rows[v][OCT_IDX_W'(oct)]};
      end
      top = {16'd0, tune_rows[v][OCT_IDX_W'(OCTAVE_SLOTS - 1)]};
      sub = {16'd0, tune_rows[v][OCT_IDX_W'(OCTAVE_SLOTS - 2)]};
      acc = (top - sub) * (oct - OCTAVE_SLOTS + 1) + top;
      return (acc > 32'd65535) ? 32'd65535 : acc;
   endfunction

   // control value of a compute word
   function automatic logic [15:0] predict_control_value(logic [2:0] voice, logic [6:0] note,
                                                         logic [7:0] fraction, logic is_pitch);
      logic [VOICE_IDX_W-1:0] v;
      logic [31:0] lo_oct;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] semi;
      logic [31:0] prod;
      logic [31:0] sum;
      if (is_pitch) begin
         return {1'b0, note, fraction};
      end
      v      = VOICE_IDX_W'(voice % VOICE_SLOTS);
      lo_oct = 32'(note) / 32'd12;
      lo     = octave_level(v, lo_oct);
      hi     = octave_level(v, lo_oct + 1);
      semi   = ((32'(note) % 32'd12 << 16) + (32'(fraction) << 8)) / 32'd12;
      prod   = semi * (hi - lo);
      sum    = lo + (prod >> 16);
      return sum[15:0];
   endfunction

   task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
      $display("%0t mismatch: %s expected %h got %h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // result check first, then prediction of the word accepted at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_cv.size() == 0) begin
               report_mismatch("result with no compute pending", 16'h0, rsp_control_value);
            end else begin
               head_cv = pending_cv.pop_front();
               n_checked++;
               if (head_cv.cv !== rsp_control_value) begin
                  report_mismatch($sformatf("control_value voice %0d note %0d frac %0d pitch %0b",
                                            head_cv.voice, head_cv.note, head_cv.fraction,
                                            head_cv.is_pitch),
                                  head_cv.cv, rsp_control_value);
               end
            end
         end
         if (start && !busy) begin
            if (req_command == ncoi_pkg::CMD_WRITE) begin
               if (req_octave_slot < OCTAVE_SLOTS) begin
                  tune_rows[VOICE_IDX_W'(req_voice % VOICE_SLOTS)]
                           [OCT_IDX_W'(req_octave_slot)] = req_entry_value;
               end
               n_writes++;
            end else begin
               head_cv.cv       = predict_control_value(req_voice, req_note, req_fraction,
                                                        req_is_pitch);
               head_cv.note     = req_note;
               head_cv.fraction = req_fraction;
               head_cv.voice    = req_voice;
               head_cv.is_pitch = req_is_pitch;
               pending_cv.push_back(head_cv);
               if (req_is_pitch) begin
                  n_pitch++;
               end else begin
                  n_table++;
                  if (32'(req_note) / 32'd12 + 1 >= OCTAVE_SLOTS) begin
                     n_extrap++;
                  end
               end
            end
         end
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog: no progress for %0d cycles", $realtime, STALL_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // drive one word at the falling edge and hold it until accepted
   task automatic send_word(logic cmd, logic [2:0] voice, logic [6:0] note, logic [7:0] fraction,
                            logic is_pitch, logic [2:0] slot, logic [15:0] value);
      if ($urandom_range(99) < idle_pct) begin
         start           <= 1'b0;
         req_command     <= 1'($urandom);
         req_voice       <= 3'($urandom);
         req_note        <= 7'($urandom);
         req_fraction    <= 8'($urandom);
         req_is_pitch    <= 1'($urandom);
         req_octave_slot <= 3'($urandom);
         req_entry_value <= 16'($urandom);
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      start           <= 1'b1;
      req_command     <= cmd;
      req_voice       <= voice;
      req_note        <= note;
      req_fraction    <= fraction;
      req_is_pitch    <= is_pitch;
      req_octave_slot <= slot;
      req_entry_value <= value;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // write words carry random don't-care fields
   task automatic write_entry(logic [2:0] voice, logic [2:0] slot, logic [15:0] value);
      send_word(ncoi_pkg::CMD_WRITE, voice, 7'($urandom), 8'($urandom), 1'($urandom), slot,
                value);
   endtask

   task automatic compute_table(logic [2:0] voice, logic [6:0] note, logic [7:0] fraction);
      send_word(ncoi_pkg::CMD_COMPUTE, voice, note, fraction, 1'b0, 3'($urandom),
                16'($urandom));
   endtask

   task automatic compute_pitch(logic [6:0] note, logic [7:0] fraction);
      send_word(ncoi_pkg::CMD_COMPUTE, 3'($urandom), note, fraction, 1'b1, 3'($urandom),
                16'($urandom));
   endtask

   function automatic logic [7:0] pick_fraction();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // direct mapping at the ends and the middle of the note range
   task automatic test_pitch_extremes();
      compute_pitch(7'd0, 8'h00);
      compute_pitch(7'd127, 8'hFF);
      compute_pitch(7'd64, 8'h80);
   endtask

   // reset rows, including the top octave and the extrapolated range
   task automatic test_reset_rows();
      compute_table(3'd0, 7'd0, 8'h00);
      compute_table(3'd7, 7'd11, 8'hFF);
      compute_table(3'd2, 7'd95, 8'hFF);
      compute_table(3'd4, 7'd96, 8'h00);
      compute_table(3'd1, 7'd127, 8'hFF);
   endtask

   // entry extremes and a falling slope between octaves
   task automatic test_entry_extremes();
      write_entry(3'd3, 3'd0, 16'h0000);
      write_entry(3'd3, 3'd1, 16'hFFFF);
      compute_table(3'd3, 7'd6, 8'h00);
      write_entry(3'd3, 3'd2, 16'h0000);
      compute_table(3'd3, 7'd18, 8'hFF);
   endtask

   // clamp at full scale, wrap of a falling top pair, unclamped falling extrapolation
   task automatic test_extrapolation();
      write_entry(3'd5, 3'd7, 16'hFFFF);
      write_entry(3'd5, 3'd6, 16'h0000);
      compute_table(3'd5, 7'd100, 8'h40);
      write_entry(3'd5, 3'd6, 16'hFFFF);
      write_entry(3'd5, 3'd7, 16'h0000);
      compute_table(3'd5, 7'd127, 8'hFF);
      write_entry(3'd5, 3'd6, 16'd1001);
      write_entry(3'd5, 3'd7, 16'd1000);
      compute_table(3'd5, 7'd120, 8'h80);
   endtask

   // random mix of writes, row loads with sweeps, pitch and table computes
   task automatic test_random_mix(int count);
      int sent;
      int pick;
      logic [2:0]  v;
      logic [2:0]  slot;
      logic [15:0] value;
      logic [15:0] step;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         v    = 3'($urandom);
         if (pick < 8) begin
            // program a whole row with a random slope, then read it back
            value = 16'($urandom);
            step  = 16'($urandom_range(0, 18000)) - 16'd9000;
            for (int k = 0; k < OCTAVE_SLOTS; k++) begin
               write_entry(v, 3'(k), value);
               value = value + step;
            end
            for (int k = 0; k < 3; k++) begin
               compute_table(v, 7'($urandom_range(0, 127)), pick_fraction());
            end
            sent += OCTAVE_SLOTS + 3;
         end else if (pick < 28) begin
            slot = 3'($urandom);
            case ($urandom_range(4))
               0: value = 16'h0000;
               1: value = 16'hFFFF;
               2: value = tune_rows[v][(slot == 3'd0) ? 3'd1 : slot - 3'd1]
                          + 16'($urandom_range(0, 8191)) - 16'd4096;
               default: value = 16'($urandom);
            endcase
            write_entry(v, slot, value);
            sent++;
         end else if (pick < 50) begin
            compute_pitch(7'($urandom), pick_fraction());
            sent++;
         end else begin
            if ($urandom_range(2) == 0) begin
               compute_table(v, 7'($urandom_range(84, 127)), pick_fraction());
            end else begin
               compute_table(v, 7'($urandom_range(0, 127)), pick_fraction());
            end
            sent++;
         end
      end
   endtask

   initial begin
      for (int v = 0; v < VOICE_SLOTS; v++) begin
         for (int k = 0; k < OCTAVE_SLOTS; k++) begin
            tune_rows[VOICE_IDX_W'(v)][OCT_IDX_W'(k)] =
               16'(ncoi_pkg::BASE_OFFSET + k * ncoi_pkg::OCTAVE_SCALE);
         end
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_pitch_extremes();
      test_reset_rows();
      test_entry_extremes();
      test_extrapolation();
      test_random_mix(350);
      idle_pct = 0;
      test_random_mix(150);
      idle_pct = 28;
      test_random_mix(250);

      // drain outstanding results, then watch for stray strobes
      start <= 1'b0;
      while (pending_cv.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_cv.size() != 0) begin
         report_mismatch("results never returned", 16'(pending_cv.size()), 16'h0);
      end

      $display("covered %0d table writes, %0d pitch and %0d table computes", n_writes, n_pitch,
               n_table);
      $display("%0d computes reached extrapolated octaves, %0d results compared, %0d mismatches",
               n_extrap, n_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== note_to_cv_octave_interpolator.f =====
hw/rtl/ncoi_pkg.sv
hw/rtl/ncoi_table.sv
hw/rtl/note_to_cv_octave_interpolator.sv
hw/rtl/ncoi_checker.sv
sim/tb_note_to_cv_octave_interpolator.sv
